// File: sv/pts_pkg.sv
// shared constants, codes and types of the periodic task table scheduler
`default_nettype none

package pts_pkg;

  localparam int unsigned MAX_TASKS_DEF = 16;
  localparam int unsigned RESULT_LIMIT  = 16;
  localparam int unsigned NDUE_W        = $clog2(RESULT_LIMIT + 1);

  localparam int unsigned OP_W    = 3;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned ID_W    = 6;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned TOTAL_W = 48;
  localparam int unsigned SHARE_W = 10;
  localparam int unsigned QUOT_W  = 11;
  localparam int unsigned NUM_W   = TOTAL_W + QUOT_W - 1;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX   = {TOTAL_W{1'b1}};
  localparam logic [SHARE_W-1:0] SHARE_SCALE = SHARE_W'(1000);

  localparam logic [OP_W-1:0] OP_REGISTER   = 3'd0;
  localparam logic [OP_W-1:0] OP_SET_ENABLE = 3'd1;
  localparam logic [OP_W-1:0] OP_TICK       = 3'd2;
  localparam logic [OP_W-1:0] OP_CHARGE     = 3'd3;
  localparam logic [OP_W-1:0] OP_QUERY      = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_REJECT = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BAD_ID = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_DIV,
    ST_NEXT,
    ST_FIN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic               per_we;
    logic               last_we;
    logic               rt_we;
    logic               en_we;
    logic [TIME_W-1:0]  per;
    logic [TIME_W-1:0]  last;
    logic [TOTAL_W-1:0] rt;
    logic               en;
  } mem_wr_t;

  typedef struct packed {
    logic [TIME_W-1:0]  per;
    logic [TIME_W-1:0]  last;
    logic [TOTAL_W-1:0] rt;
    logic               en;
  } mem_rd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_st_t;

endpackage

`default_nettype wire

// File: sv/pts_if.sv
// request and response channel interfaces of the scheduler
`default_nettype none

interface pts_req_if import pts_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [TIME_W-1:0] now_ms;
  logic [TIME_W-1:0] period_ms;
  logic              handler_present;
  logic [ID_W-1:0]   slot;
  logic              enable_flag;
  logic [TIME_W-1:0] elapsed_us;

  modport source (
    output valid, op, now_ms, period_ms, handler_present, slot, enable_flag, elapsed_us,
    input  ready
  );
  modport sink (
    input  valid, op, now_ms, period_ms, handler_present, slot, enable_flag, elapsed_us,
    output ready
  );
endinterface

interface pts_rsp_if import pts_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic [ID_W-1:0]    task_id;
  logic               due;
  logic               last;
  logic               task_enabled;
  logic [TIME_W-1:0]  task_period_ms;
  logic [TOTAL_W-1:0] run_total_us;
  logic [SHARE_W-1:0] share_x10;

  modport source (
    output valid, status, task_id, due, last, task_enabled, task_period_ms,
           run_total_us, share_x10,
    input  ready
  );
  modport sink (
    input  valid, status, task_id, due, last, task_enabled, task_period_ms,
           run_total_us, share_x10,
    output ready
  );
endinterface

`default_nettype wire

// File: sv/periodic_task_table_scheduler.sv
// top level of the periodic task table scheduler
`default_nettype none

// Takes one request at a time and is not ready until that request's results
// are all handed to the response register. Register, set enable and charge
// pass through accept, table read, execute and response load. A query adds
// the share divider, eleven quotient steps and a hand-over of the quotient. A
// tick reads the table one task at a time through its single port: each
// scanned task passes through table read, execute and scan-next states, a due
// task held from before is pushed out through the emit state, and the scan
// ends with the finish and emit states. A response waiting on a stalled sink
// holds the block only when the next response must be loaded.
module periodic_task_table_scheduler import pts_pkg::*; #(
  parameter int unsigned MAX_TASKS = MAX_TASKS_DEF
) (
  input  logic clk,
  input  logic rst,
  pts_req_if.sink   req,
  pts_rsp_if.source rsp
);

  localparam int unsigned IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned CW = $clog2(MAX_TASKS + 1);
  localparam logic [CW-1:0] COUNT_FULL = CW'(MAX_TASKS);

  function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] a,
                                                 input logic [TIME_W-1:0]  b);
    logic [TOTAL_W:0] s;
    s = {1'b0, a} + (TOTAL_W + 1)'(b);
    return s[TOTAL_W] ? TOTAL_MAX : s[TOTAL_W-1:0];
  endfunction

  state_t state, state_next;

  logic [OP_W-1:0]   op_q;
  logic [TIME_W-1:0] now_q;
  logic [TIME_W-1:0] per_q;
  logic              handler_q;
  logic [ID_W-1:0]   slot_q;
  logic              en_q;
  logic [TIME_W-1:0] el_q;
  logic              slot_ok;

  logic [IW-1:0]      idx;
  logic [CW-1:0]      entry_count;
  logic [TOTAL_W-1:0] grand;
  logic [NDUE_W-1:0]  n_due;
  logic               pend_valid;
  logic [IW-1:0]      pend_id;

  logic [STAT_W-1:0]  r_status;
  logic [ID_W-1:0]    r_id;
  logic               r_due;
  logic               r_last;
  logic               r_en;
  logic [TIME_W-1:0]  r_per;
  logic [TOTAL_W-1:0] r_tot;
  logic [SHARE_W-1:0] r_share;

  logic               out_valid;
  logic [STAT_W-1:0]  o_status;
  logic [ID_W-1:0]    o_id;
  logic               o_due;
  logic               o_last;
  logic               o_en;
  logic [TIME_W-1:0]  o_per;
  logic [TOTAL_W-1:0] o_tot;
  logic [SHARE_W-1:0] o_share;

  logic acc;
  logic out_free;
  logic load_out;
  logic op_known;
  logic reg_ok;
  logic tick_due;
  logic scan_end;
  logic acc_slot_ok;

  logic [ID_W:0] slot_ext;
  logic [ID_W:0] count_ext;
  logic [CW-1:0] idx_inc;

  mem_wr_t            wr;
  mem_rd_t            rd;
  div_st_t            div_st;
  logic               div_start;
  logic [NUM_W-1:0]   div_num;
  logic [TOTAL_W-1:0] div_den;
  logic [QUOT_W-1:0]  div_quot;

  pts_mem #(
    .MAX_TASKS (MAX_TASKS),
    .IW        (IW)
  ) u_mem (
    .clk  (clk),
    .rst  (rst),
    .addr (idx),
    .wr   (wr),
    .rd   (rd)
  );

  pts_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .st    (div_st),
    .quot  (div_quot)
  );

  assign req.ready   = (state == ST_IDLE);
  assign acc         = req.valid && (state == ST_IDLE);
  assign out_free    = !out_valid || rsp.ready;
  assign op_known    = req.op <= OP_QUERY;
  assign slot_ext    = {1'b0, req.slot};
  assign count_ext   = (ID_W + 1)'(entry_count);
  assign acc_slot_ok = slot_ext < count_ext;
  assign reg_ok      = (entry_count < COUNT_FULL) && handler_q;
  assign tick_due    = rd.en && ((now_q - rd.last) >= rd.per);
  assign idx_inc     = CW'(idx) + CW'(1);
  assign scan_end    = (idx_inc == entry_count) || (n_due == NDUE_W'(RESULT_LIMIT));

  // total * 1000 as shift and subtract
  assign div_num = (NUM_W'(rd.rt) << 10) - (NUM_W'(rd.rt) << 4) - (NUM_W'(rd.rt) << 3);
  assign div_den = (grand == '0) ? TOTAL_W'(1) : grand;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    wr         = '0;
    div_start  = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (acc && op_known) begin
          if (req.op == OP_TICK && entry_count == '0) begin
            state_next = ST_FIN;
          end else begin
            state_next = ST_READ;
          end
        end
      end
      ST_READ: begin
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = ST_EMIT;
        case (op_q)
          OP_REGISTER: begin
            if (reg_ok) begin
              wr.per_we  = 1'b1;
              wr.last_we = 1'b1;
              wr.en_we   = 1'b1;
              wr.per     = (per_q == '0) ? TIME_W'(1) : per_q;
              wr.last    = '0;
              wr.en      = 1'b1;
            end
          end
          OP_SET_ENABLE: begin
            if (slot_ok) begin
              wr.en_we = 1'b1;
              wr.en    = en_q;
            end
          end
          OP_CHARGE: begin
            if (slot_ok) begin
              wr.rt_we = 1'b1;
              wr.rt    = sat_add(rd.rt, el_q);
            end
          end
          OP_QUERY: begin
            if (slot_ok) begin
              div_start  = 1'b1;
              state_next = ST_DIV;
            end
          end
          OP_TICK: begin
            state_next = ST_NEXT;
            if (tick_due) begin
              wr.last_we = 1'b1;
              wr.last    = now_q;
              if (pend_valid) begin
                state_next = ST_EMIT;
              end
            end
          end
          default: begin
            state_next = ST_IDLE;
          end
        endcase
      end
      ST_DIV: begin
        if (div_st.done) begin
          state_next = ST_EMIT;
        end
      end
      ST_NEXT: begin
        state_next = scan_end ? ST_FIN : ST_READ;
      end
      ST_FIN: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = r_last ? ST_IDLE : ST_NEXT;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      grand       <= '0;
      n_due       <= '0;
      pend_valid  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (acc) begin
        n_due      <= '0;
        pend_valid <= 1'b0;
      end
      if (state == ST_EXEC) begin
        if (op_q == OP_REGISTER && reg_ok) begin
          entry_count <= entry_count + CW'(1);
        end
        if (op_q == OP_CHARGE && slot_ok) begin
          grand <= sat_add(grand, el_q);
        end
        if (op_q == OP_TICK && tick_due) begin
          n_due      <= n_due + NDUE_W'(1);
          pend_valid <= 1'b1;
        end
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // request fields, scan index and staged response
  always_ff @(posedge clk) begin
    if (acc) begin
      op_q      <= req.op;
      now_q     <= req.now_ms;
      per_q     <= req.period_ms;
      handler_q <= req.handler_present;
      slot_q    <= req.slot;
      en_q      <= req.enable_flag;
      el_q      <= req.elapsed_us;
      slot_ok   <= acc_slot_ok;
      if (req.op == OP_TICK) begin
        idx <= '0;
      end else if (req.op == OP_REGISTER) begin
        idx <= (entry_count < COUNT_FULL) ? entry_count[IW-1:0] : '0;
      end else begin
        idx <= acc_slot_ok ? req.slot[IW-1:0] : '0;
      end
      r_status <= STAT_OK;
      r_id     <= '0;
      r_due    <= 1'b0;
      r_last   <= 1'b1;
      r_en     <= 1'b0;
      r_per    <= '0;
      r_tot    <= '0;
      r_share  <= '0;
    end
    if (state == ST_EXEC) begin
      case (op_q) inside
        OP_REGISTER: begin
          if (reg_ok) begin
            r_id <= ID_W'(idx);
          end else begin
            r_status <= STAT_REJECT;
          end
        end
        OP_SET_ENABLE, OP_CHARGE, OP_QUERY: begin
          r_id     <= slot_q;
          r_status <= slot_ok ? STAT_OK : STAT_BAD_ID;
          if (op_q == OP_QUERY && slot_ok) begin
            r_en  <= rd.en;
            r_per <= rd.per;
            r_tot <= rd.rt;
          end
        end
        OP_TICK: begin
          if (tick_due) begin
            pend_id <= idx;
            if (pend_valid) begin
              r_status <= STAT_OK;
              r_id     <= ID_W'(pend_id);
              r_due    <= 1'b1;
              r_last   <= 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
    if (state == ST_DIV && div_st.done) begin
      r_share <= (div_quot > QUOT_W'(SHARE_SCALE)) ? SHARE_SCALE : div_quot[SHARE_W-1:0];
    end
    if (state == ST_NEXT && !scan_end) begin
      idx <= idx_inc[IW-1:0];
    end
    if (state == ST_FIN) begin
      r_status <= STAT_OK;
      r_last   <= 1'b1;
      r_due    <= pend_valid;
      r_id     <= pend_valid ? ID_W'(pend_id) : '0;
    end
    if (load_out) begin
      o_status <= r_status;
      o_id     <= r_id;
      o_due    <= r_due;
      o_last   <= r_last;
      o_en     <= r_en;
      o_per    <= r_per;
      o_tot    <= r_tot;
      o_share  <= r_share;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.status         = o_status;
  assign rsp.task_id        = o_id;
  assign rsp.due            = o_due;
  assign rsp.last           = o_last;
  assign rsp.task_enabled   = o_en;
  assign rsp.task_period_ms = o_per;
  assign rsp.run_total_us   = o_tot;
  assign rsp.share_x10      = o_share;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= COUNT_FULL)
    else $error("task count beyond table size");

  a_div_running: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> div_st.busy || div_st.done)
    else $error("waiting on an idle divider");

  a_tick_continues: assert property (@(posedge clk) disable iff (rst)
    load_out && !r_last |=> state == ST_NEXT)
    else $error("scan did not resume after a non-final tick response");

  a_due_limit: assert property (@(posedge clk) disable iff (rst)
    n_due <= NDUE_W'(RESULT_LIMIT))
    else $error("too many due responses for one tick");

endmodule

`default_nettype wire

// File: sv/pts_mem.sv
// task table storage with one shared address and registered read data
`default_nettype none

module pts_mem import pts_pkg::*; #(
  parameter int unsigned MAX_TASKS = MAX_TASKS_DEF,
  parameter int unsigned IW        = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [IW-1:0] addr,
  input  mem_wr_t       wr,
  output mem_rd_t       rd
);

  logic [TIME_W-1:0]  period_mem [MAX_TASKS];
  logic [TIME_W-1:0]  last_mem   [MAX_TASKS];
  logic [TOTAL_W-1:0] rt_mem     [MAX_TASKS];
  logic [MAX_TASKS-1:0] en_bits;
  logic [MAX_TASKS-1:0] rt_ok;

  logic [TIME_W-1:0]  per_q;
  logic [TIME_W-1:0]  last_q;
  logic [TOTAL_W-1:0] rt_q;
  logic               rt_ok_q;
  logic               en_q;

  always_ff @(posedge clk) begin
    if (wr.per_we) begin
      period_mem[addr] <= wr.per;
    end
    if (wr.last_we) begin
      last_mem[addr] <= wr.last;
    end
    if (wr.rt_we) begin
      rt_mem[addr] <= wr.rt;
    end
    per_q  <= period_mem[addr];
    last_q <= last_mem[addr];
    rt_q   <= rt_mem[addr];
  end

  // run-time entries read as zero until first charged
  always_ff @(posedge clk) begin
    if (rst) begin
      en_bits <= '0;
      rt_ok   <= '0;
      rt_ok_q <= 1'b0;
      en_q    <= 1'b0;
    end else begin
      if (wr.en_we) begin
        en_bits[addr] <= wr.en;
      end
      if (wr.rt_we) begin
        rt_ok[addr] <= 1'b1;
      end
      rt_ok_q <= rt_ok[addr];
      en_q    <= en_bits[addr];
    end
  end

  always_comb begin
    rd.per  = per_q;
    rd.last = last_q;
    rd.rt   = rt_ok_q ? rt_q : '0;
    rd.en   = en_q;
  end

endmodule

`default_nettype wire

// File: sv/pts_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none

module pts_div import pts_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [NUM_W-1:0]   num,
  input  logic [TOTAL_W-1:0] den,
  output div_st_t            st,
  output logic [QUOT_W-1:0]  quot
);

  localparam int unsigned CNT_W = $clog2(QUOT_W + 1);

  logic [NUM_W-1:0] rem;
  logic [NUM_W-1:0] dsh;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic             fits;

  assign fits = rem >= dsh;

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= num;
      dsh  <= NUM_W'(den) << (QUOT_W - 1);
      quot <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= rem - dsh;
      end
      dsh  <= dsh >> 1;
      quot <= {quot[QUOT_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(QUOT_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign st.busy = busy;
  assign st.done = done;

endmodule

`default_nettype wire

// File: sim/tb_top.sv
// self-checking testbench for the periodic task table scheduler: directed and random requests
module tb_top;
  import pts_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 3_000_000;
  localparam int unsigned BIG_CHARGES  = 8;
  localparam int unsigned RAND_PER_PHASE = 28;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [TIME_W-1:0] now_ms;
    logic [TIME_W-1:0] period_ms;
    logic              handler_present;
    logic [ID_W-1:0]   slot;
    logic              enable_flag;
    logic [TIME_W-1:0] elapsed_us;
    logic              hold;
  } sched_req_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [ID_W-1:0]    task_id;
    logic               due;
    logic               last;
    logic               task_enabled;
    logic [TIME_W-1:0]  task_period_ms;
    logic [TOTAL_W-1:0] run_total_us;
    logic [SHARE_W-1:0] share_x10;
  } sched_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pts_req_if req_ch ();
  pts_rsp_if rsp_ch ();

  periodic_task_table_scheduler i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #5 clk = ~clk;

  sched_req_t pending_req[$];
  sched_rsp_t awaited_rsp[$];
  sched_req_t cur_req;

  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  int unsigned fail_count = 0;
  int unsigned rsp_seen = 0;
  int unsigned cycle_count = 0;
  logic [TIME_W-1:0] clock_ms = '0;

  // scheduler state as the block should hold it
  int unsigned        tbl_count = 0;
  logic [TIME_W-1:0]  tbl_period   [MAX_TASKS_DEF] = '{default: '0};
  logic [TIME_W-1:0]  tbl_last_run [MAX_TASKS_DEF] = '{default: '0};
  logic               tbl_enable   [MAX_TASKS_DEF] = '{default: 1'b0};
  logic [TOTAL_W-1:0] tbl_runtime  [MAX_TASKS_DEF] = '{default: '0};
  logic [TOTAL_W-1:0] sum_runtime = '0;

  function automatic logic [TOTAL_W-1:0] add_saturated(logic [TOTAL_W-1:0] a,
                                                       logic [TIME_W-1:0] b);
    logic [TOTAL_W:0] sum;
    sum = {1'b0, a} + (TOTAL_W + 1)'(b);
    return sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
  endfunction

  task automatic predict_schedule(input sched_req_t r);
    sched_rsp_t rs;
    sched_rsp_t held;
    bit has_held;
    bit id_ok;
    int unsigned found;
    int unsigned i;
    logic [TIME_W-1:0] since_ms;
    logic [63:0] grand_div;
    logic [63:0] share_full;
    rs = '0;
    rs.last = 1'b1;
    has_held = 0;
    found = 0;
    id_ok = r.slot < tbl_count;
    case (r.op)
      OP_REGISTER: begin
        if (tbl_count >= MAX_TASKS_DEF || !r.handler_present) begin
          rs.status = STAT_REJECT;
        end else begin
          tbl_period[tbl_count]   = (r.period_ms == 0) ? TIME_W'(1) : r.period_ms;
          tbl_last_run[tbl_count] = '0;
          tbl_enable[tbl_count]   = 1'b1;
          rs.task_id = ID_W'(tbl_count);
          tbl_count++;
        end
        awaited_rsp.push_back(rs);
      end
      OP_SET_ENABLE: begin
        rs.task_id = r.slot;
        if (id_ok) tbl_enable[r.slot] = r.enable_flag;
        else rs.status = STAT_BAD_ID;
        awaited_rsp.push_back(rs);
      end
      OP_TICK: begin
        for (i = 0; i < tbl_count && found < RESULT_LIMIT; i++) begin
          since_ms = r.now_ms - tbl_last_run[i];
          if (tbl_enable[i] && since_ms >= tbl_period[i]) begin
            tbl_last_run[i] = r.now_ms;
            if (has_held) awaited_rsp.push_back(held);
            held = '0;
            held.task_id = ID_W'(i);
            held.due = 1'b1;
            has_held = 1;
            found++;
          end
        end
        if (has_held) begin
          held.last = 1'b1;
          awaited_rsp.push_back(held);
        end else begin
          awaited_rsp.push_back(rs);
        end
      end
      OP_CHARGE: begin
        rs.task_id = r.slot;
        if (id_ok) begin
          tbl_runtime[r.slot] = add_saturated(tbl_runtime[r.slot], r.elapsed_us);
          sum_runtime = add_saturated(sum_runtime, r.elapsed_us);
        end else begin
          rs.status = STAT_BAD_ID;
        end
        awaited_rsp.push_back(rs);
      end
      OP_QUERY: begin
        rs.task_id = r.slot;
        if (id_ok) begin
          grand_div = (sum_runtime == 0) ? 64'd1 : 64'(sum_runtime);
          share_full = (64'(tbl_runtime[r.slot]) * 64'd1000) / grand_div;
          if (share_full > 64'd1000) share_full = 64'd1000;
          rs.task_enabled   = tbl_enable[r.slot];
          rs.task_period_ms = tbl_period[r.slot];
          rs.run_total_us   = tbl_runtime[r.slot];
          rs.share_x10      = share_full[SHARE_W-1:0];
        end else begin
          rs.status = STAT_BAD_ID;
        end
        awaited_rsp.push_back(rs);
      end
      default: begin
      end
    endcase
  endtask

  task automatic report_mismatch(input string name, input logic [63:0] got_v,
                                 input logic [63:0] want_v);
    $display("mismatch at response %0d, %s: got %0h expected %0h",
             rsp_seen, name, got_v, want_v);
    fail_count++;
  endtask

  // request driver
  always @(posedge clk) begin : drive_requests
    sched_req_t nxt;
    bit offer;
    if (rst) begin
      req_ch.valid           <= 1'b0;
      req_ch.op              <= OP_REGISTER;
      req_ch.now_ms          <= '0;
      req_ch.period_ms       <= '0;
      req_ch.handler_present <= 1'b0;
      req_ch.slot            <= '0;
      req_ch.enable_flag     <= 1'b0;
      req_ch.elapsed_us      <= '0;
    end else begin
      if (req_ch.valid && req_ch.ready) predict_schedule(cur_req);
      if (!req_ch.valid || req_ch.ready) begin
        offer = pending_req.size() != 0 && $urandom_range(99) >= idle_pct;
        if (offer) begin
          nxt = pending_req[0];
          if (nxt.hold && awaited_rsp.size() != 0) offer = 0;
        end
        if (offer) begin
          cur_req = pending_req.pop_front();
          req_ch.op              <= cur_req.op;
          req_ch.now_ms          <= cur_req.now_ms;
          req_ch.period_ms       <= cur_req.period_ms;
          req_ch.handler_present <= cur_req.handler_present;
          req_ch.slot            <= cur_req.slot;
          req_ch.enable_flag     <= cur_req.enable_flag;
          req_ch.elapsed_us      <= cur_req.elapsed_us;
          req_ch.valid           <= 1'b1;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) rsp_ch.ready <= 1'b0;
    else rsp_ch.ready <= $urandom_range(99) >= stall_pct;
  end

  // response monitor
  always @(posedge clk) begin : watch_responses
    sched_rsp_t got;
    sched_rsp_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got.status         = rsp_ch.status;
      got.task_id        = rsp_ch.task_id;
      got.due            = rsp_ch.due;
      got.last           = rsp_ch.last;
      got.task_enabled   = rsp_ch.task_enabled;
      got.task_period_ms = rsp_ch.task_period_ms;
      got.run_total_us   = rsp_ch.run_total_us;
      got.share_x10      = rsp_ch.share_x10;
      if (awaited_rsp.size() == 0) begin
        report_mismatch("unexpected response, task_id", 64'(got.task_id), 64'd0);
      end else begin
        want = awaited_rsp.pop_front();
        if (got.status !== want.status)
          report_mismatch("status", 64'(got.status), 64'(want.status));
        if (got.task_id !== want.task_id)
          report_mismatch("task_id", 64'(got.task_id), 64'(want.task_id));
        if (got.due !== want.due)
          report_mismatch("due", 64'(got.due), 64'(want.due));
        if (got.last !== want.last)
          report_mismatch("last", 64'(got.last), 64'(want.last));
        if (got.task_enabled !== want.task_enabled)
          report_mismatch("task_enabled", 64'(got.task_enabled), 64'(want.task_enabled));
        if (got.task_period_ms !== want.task_period_ms)
          report_mismatch("task_period_ms", 64'(got.task_period_ms),
                          64'(want.task_period_ms));
        if (got.run_total_us !== want.run_total_us)
          report_mismatch("run_total_us", 64'(got.run_total_us),
                          64'(want.run_total_us));
        if (got.share_x10 !== want.share_x10)
          report_mismatch("share_x10", 64'(got.share_x10), 64'(want.share_x10));
      end
      rsp_seen++;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic sched_req_t make_req(logic [OP_W-1:0] op, logic [TIME_W-1:0] now_v,
                                          logic [TIME_W-1:0] period_v, logic handler,
                                          logic [ID_W-1:0] slot_v, logic en,
                                          logic [TIME_W-1:0] elapsed_v);
    sched_req_t r;
    r.op = op;
    r.now_ms = now_v;
    r.period_ms = period_v;
    r.handler_present = handler;
    r.slot = slot_v;
    r.enable_flag = en;
    r.elapsed_us = elapsed_v;
    r.hold = 1'b0;
    return r;
  endfunction

  function automatic sched_req_t random_req();
    sched_req_t r;
    int unsigned pick;
    r.now_ms          = $urandom;
    r.period_ms       = $urandom;
    r.handler_present = 1'($urandom_range(1));
    r.slot            = ($urandom_range(6) != 0) ? ID_W'($urandom_range(17))
                                                 : ID_W'($urandom);
    r.enable_flag     = $urandom_range(9) < 7;
    r.elapsed_us      = $urandom;
    r.hold            = $urandom_range(19) == 0;
    pick = $urandom_range(99);
    if (pick < 8) begin
      r.op = OP_REGISTER;
      r.handler_present = $urandom_range(9) != 0;
      r.period_ms = ($urandom_range(9) == 0) ? '0 : TIME_W'($urandom_range(60, 1));
    end else if (pick < 20) begin
      r.op = OP_SET_ENABLE;
    end else if (pick < 55) begin
      r.op = OP_TICK;
      if ($urandom_range(9) == 0) clock_ms = $urandom;
      else clock_ms = clock_ms + TIME_W'($urandom_range(20));
      r.now_ms = clock_ms;
    end else if (pick < 80) begin
      r.op = OP_CHARGE;
      if ($urandom_range(9) < 8) r.elapsed_us = TIME_W'($urandom_range(100000));
    end else if (pick < 95) begin
      r.op = OP_QUERY;
    end else begin
      r.op = OP_QUERY + OP_W'($urandom_range(3, 1));
    end
    return r;
  endfunction

  task automatic wait_drained();
    while (pending_req.size() != 0 || req_ch.valid || awaited_rsp.size() != 0)
      @(posedge clk);
  endtask

  initial begin : stimulus
    int unsigned send_idle [4];
    int unsigned recv_stall [4];
    logic [TIME_W-1:0] all_due_ms;
    sched_req_t held_req;
    send_idle  = '{0, 73, 0, 16};
    recv_stall = '{0, 0, 73, 16};
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // empty table, bad ids, rejected and accepted registers, wrapping ticks
    pending_req.push_back(make_req(OP_TICK, '0, '0, 1'b0, '0, 1'b0, '0));
    pending_req.push_back(make_req(OP_QUERY, '0, '0, 1'b0, '0, 1'b0, '0));
    pending_req.push_back(make_req(OP_SET_ENABLE, '0, '0, 1'b0, 6'd63, 1'b1, '0));
    pending_req.push_back(make_req(OP_CHARGE, '1, '1, 1'b1, 6'd63, 1'b1, '1));
    pending_req.push_back(make_req(OP_REGISTER, '0, 32'd5, 1'b0, '0, 1'b0, '0));
    pending_req.push_back(make_req(OP_REGISTER, '0, '0, 1'b1, '0, 1'b0, '0));
    pending_req.push_back(make_req(OP_REGISTER, '0, '1, 1'b1, '0, 1'b0, '0));
    pending_req.push_back(make_req(OP_TICK, '0, '0, 1'b0, '0, 1'b0, '0));
    pending_req.push_back(make_req(OP_TICK, 32'd1, '0, 1'b0, '0, 1'b0, '0));
    pending_req.push_back(make_req(OP_TICK, '1, '0, 1'b0, '0, 1'b0, '0));
    pending_req.push_back(make_req(OP_CHARGE, '0, '0, 1'b0, 6'd0, 1'b0, '0));
    pending_req.push_back(make_req(OP_CHARGE, '0, '0, 1'b0, 6'd0, 1'b0, '1));
    pending_req.push_back(make_req(OP_CHARGE, '0, '0, 1'b0, 6'd1, 1'b0, 32'd1));
    pending_req.push_back(make_req(OP_QUERY, '0, '0, 1'b0, 6'd0, 1'b0, '0));
    pending_req.push_back(make_req(OP_QUERY, '0, '0, 1'b0, 6'd1, 1'b0, '0));
    pending_req.push_back(make_req(OP_QUERY, '0, '0, 1'b0, 6'd2, 1'b0, '0));
    pending_req.push_back(make_req(OP_SET_ENABLE, '0, '0, 1'b0, 6'd0, 1'b0, '0));
    pending_req.push_back(make_req(OP_TICK, 32'd5, '0, 1'b0, '0, 1'b0, '0));
    pending_req.push_back(make_req(OP_QUERY, '0, '0, 1'b0, 6'd0, 1'b0, '0));
    pending_req.push_back(make_req(OP_SET_ENABLE, '0, '0, 1'b0, 6'd0, 1'b1, '0));
    pending_req.push_back(make_req(OP_QUERY + OP_W'(1), '1, '1, 1'b1, '1, 1'b1, '1));
    pending_req.push_back(make_req(OP_QUERY + OP_W'(2), '0, '0, 1'b0, '0, 1'b0, '0));
    pending_req.push_back(make_req(OP_QUERY + OP_W'(3), '1, '0, 1'b1, 6'd1, 1'b0, '1));
    pending_req.push_back(make_req(OP_TICK, '0, '0, 1'b0, '0, 1'b0, '0));
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      idle_pct  = send_idle[p];
      stall_pct = recv_stall[p];
      for (int n = 0; n < RAND_PER_PHASE; n++) pending_req.push_back(random_req());
      wait_drained();
    end

    // fill the table, enable every task and tick so that all can be due at once
    idle_pct  = 0;
    stall_pct = 0;
    for (int n = 0; n < MAX_TASKS_DEF + 1; n++)
      pending_req.push_back(make_req(OP_REGISTER, '0, TIME_W'(n % 7), 1'b1, '0, 1'b0, '0));
    for (int n = 0; n < MAX_TASKS_DEF; n++)
      pending_req.push_back(make_req(OP_SET_ENABLE, '0, '0, 1'b0, ID_W'(n), 1'b1, '0));
    wait_drained();
    all_due_ms = tbl_last_run[1] - TIME_W'(1);
    pending_req.push_back(make_req(OP_TICK, all_due_ms, '0, 1'b0, '0, 1'b0, '0));
    wait_drained();

    // large charges, then query every entry and one past the end
    for (int n = 0; n < BIG_CHARGES; n++)
      pending_req.push_back(make_req(OP_CHARGE, '0, '0, 1'b0, 6'd0, 1'b0, '1));
    for (int n = 0; n <= MAX_TASKS_DEF; n++)
      pending_req.push_back(make_req(OP_QUERY, '0, '0, 1'b0, ID_W'(n), 1'b0, '0));
    pending_req.push_back(make_req(OP_CHARGE, '0, '0, 1'b0, 6'd3, 1'b0, 32'd7));
    held_req = make_req(OP_QUERY, '0, '0, 1'b0, 6'd3, 1'b0, '0);
    held_req.hold = 1'b1;
    pending_req.push_back(held_req);
    pending_req.push_back(make_req(OP_QUERY, '0, '0, 1'b0, 6'd0, 1'b0, '0));
    wait_drained();

    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
